// File: hdl/ksct_pkg.sv
`timescale 1ns / 1ps

package ksct_pkg;

	localparam int KEY_W   = 64;
	localparam int COUNT_W = 32;
	localparam int AMT_W   = 16;
	localparam int MODE_W  = 2;
	localparam int KIND_W  = 3;

	localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_LIST   = 2'd2;

	localparam logic [KIND_W-1:0] KIND_UPDATED   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_INSERTED  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd2;
	localparam logic [KIND_W-1:0] KIND_FULL      = 3'd3;
	localparam logic [KIND_W-1:0] KIND_LISTED    = 3'd4;
	localparam logic [KIND_W-1:0] KIND_SEPARATOR = 3'd5;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Search token that walks down the row of cells, one cell per cycle.
	typedef struct packed {
		logic               valid;
		logic [MODE_W-1:0]  mode;
		logic [KEY_W-1:0]   key;
		logic [AMT_W-1:0]   amount;
		logic               hit;
		logic               inserted;
		logic [COUNT_W-1:0] count;
	} tok_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_LIST,
		ST_SEP
	} state_t;

endpackage

// File: hdl/ksct_cell.sv
`timescale 1ns / 1ps

module ksct_cell
	import ksct_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  tok_t                tok_in,
	output tok_t                tok_out,
	input  logic                occupied,
	input  logic                append_slot,
	input  logic                rotate,
	input  logic [KEY_W-1:0]    rot_key,
	input  logic [COUNT_W-1:0]  rot_count,
	output logic [KEY_W-1:0]    key,
	output logic [COUNT_W-1:0]  count
);

	tok_t               tok_q, tok_d;
	logic [KEY_W-1:0]   key_q, key_d;
	logic [COUNT_W-1:0] count_q, count_d;
	logic [COUNT_W:0]   sum;

	always_comb begin
		tok_d   = tok_in;
		key_d   = key_q;
		count_d = count_q;
		sum     = {1'b0, count_q} + {{(COUNT_W+1-AMT_W){1'b0}}, tok_in.amount};
		if (rotate) begin
			key_d   = rot_key;
			count_d = rot_count;
		end else if (tok_in.valid && !tok_in.hit && !tok_in.inserted) begin
			if (occupied && key_q == tok_in.key) begin
				if (tok_in.mode == MODE_ADD) begin
					count_d = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
				end else begin
					count_d = (count_q >= {{(COUNT_W-AMT_W){1'b0}}, tok_in.amount})
						? count_q - {{(COUNT_W-AMT_W){1'b0}}, tok_in.amount}
						: '0;
				end
				tok_d.hit   = 1'b1;
				tok_d.count = count_d;
			end else if (append_slot && tok_in.mode == MODE_ADD) begin
				// First free cell reached without a hit: the key is new.
				key_d          = tok_in.key;
				count_d        = {{(COUNT_W-AMT_W){1'b0}}, tok_in.amount};
				tok_d.inserted = 1'b1;
				tok_d.count    = count_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	always_ff @(posedge clk) begin
		key_q   <= key_d;
		count_q <= count_d;
	end

	assign tok_out = tok_q;
	assign key     = key_q;
	assign count   = count_q;

endmodule

// File: hdl/keyed_saturating_counter_table.sv
`timescale 1ns / 1ps

// Table of up to CAPACITY key/count pairs held in a row of cells, one entry per cell,
// in insertion order. In an add or remove a search token walks the row one cell per
// cycle and the result strobe is registered from the token leaving the last cell. In a
// list the row rotates once around, one entry per cycle, and every occupied entry is
// shown at cell zero, followed by the separator. busy is high while an item is in work
// and falls in the cycle of its final result. Each result is on the ports for one cycle
// only, marked by result_valid; the receiver cannot hold it off. Mode three is taken and
// dropped without a result.
module keyed_saturating_counter_table
	import ksct_pkg::*;
#(
	parameter int CAPACITY = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [MODE_W-1:0]   mode,
	input  logic [KEY_W-1:0]    item_key,
	input  logic [AMT_W-1:0]    amount,
	output logic                result_valid,
	output logic [KEY_W-1:0]    entry_key,
	output logic [COUNT_W-1:0]  entry_count,
	output logic [KIND_W-1:0]   kind,
	output logic                last
);

	localparam int USED_W = $clog2(CAPACITY + 1);

	state_t              state_q, state_d;
	logic [USED_W-1:0]   used_q, used_d;
	logic [USED_W-1:0]   cnt_q, cnt_d;
	logic                accept;
	logic                rotate;

	logic                res_valid_q, res_valid_d;
	logic [KEY_W-1:0]    res_key_q, res_key_d;
	logic [COUNT_W-1:0]  res_count_q, res_count_d;
	logic [KIND_W-1:0]   res_kind_q, res_kind_d;
	logic                res_last_q, res_last_d;

	tok_t                tok_head;
	tok_t                tok [CAPACITY+1];
	logic [KEY_W-1:0]    cell_key [CAPACITY];
	logic [COUNT_W-1:0]  cell_count [CAPACITY];

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	always_comb begin
		tok_head        = '0;
		tok_head.valid  = accept && (mode == MODE_ADD || mode == MODE_REMOVE);
		tok_head.mode   = mode;
		tok_head.key    = item_key;
		tok_head.amount = amount;
	end

	assign tok[0] = tok_head;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		ksct_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.tok_in      (tok[i]),
			.tok_out     (tok[i+1]),
			.occupied    (USED_W'(i) < used_q),
			.append_slot (USED_W'(i) == used_q),
			.rotate      (rotate),
			.rot_key     (cell_key[(i + 1) % CAPACITY]),
			.rot_count   (cell_count[(i + 1) % CAPACITY]),
			.key         (cell_key[i]),
			.count       (cell_count[i])
		);
	end

	always_comb begin
		state_d     = state_q;
		used_d      = used_q;
		cnt_d       = cnt_q;
		rotate      = 1'b0;
		res_valid_d = 1'b0;
		res_key_d   = '0;
		res_count_d = '0;
		res_kind_d  = KIND_UPDATED;
		res_last_d  = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cnt_d = '0;
					if (mode == MODE_ADD || mode == MODE_REMOVE) begin
						state_d = ST_SEARCH;
					end else if (mode == MODE_LIST) begin
						state_d = ST_LIST;
					end
				end
			end
			ST_SEARCH: begin
				if (tok[CAPACITY].valid) begin
					res_valid_d = 1'b1;
					state_d     = ST_IDLE;
					if (tok[CAPACITY].hit) begin
						res_kind_d  = KIND_UPDATED;
						res_count_d = tok[CAPACITY].count;
					end else if (tok[CAPACITY].inserted) begin
						res_kind_d  = KIND_INSERTED;
						res_count_d = tok[CAPACITY].count;
						used_d      = used_q + 1'b1;
					end else if (tok[CAPACITY].mode == MODE_ADD) begin
						res_kind_d = KIND_FULL;
					end else begin
						res_kind_d = KIND_NOT_FOUND;
					end
				end
			end
			ST_LIST: begin
				// A full turn of the ring brings every cell back to its own entry.
				rotate = 1'b1;
				if (cnt_q < used_q) begin
					res_valid_d = 1'b1;
					res_key_d   = cell_key[0];
					res_count_d = cell_count[0];
					res_kind_d  = KIND_LISTED;
					res_last_d  = 1'b0;
				end
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == USED_W'(CAPACITY - 1)) begin
					state_d = ST_SEP;
				end
			end
			ST_SEP: begin
				res_valid_d = 1'b1;
				res_kind_d  = KIND_SEPARATOR;
				state_d     = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			used_q      <= used_d;
			cnt_q       <= cnt_d;
			res_valid_q <= res_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		res_key_q   <= res_key_d;
		res_count_q <= res_count_d;
		res_kind_q  <= res_kind_d;
		res_last_q  <= res_last_d;
	end

	assign result_valid = res_valid_q;
	assign entry_key    = res_key_q;
	assign entry_count  = res_count_q;
	assign kind         = res_kind_q;
	assign last         = res_last_q;

endmodule
